/* hdl/tinted_alpha_over_compositor_assert.svh */
// assertion macros for the tinted alpha-over compositor checker
// expects signals named clk and rst in the scope of use
`ifndef TINTED_ALPHA_OVER_COMPOSITOR_ASSERT_SVH
`define TINTED_ALPHA_OVER_COMPOSITOR_ASSERT_SVH

// same-cycle implication, off while in reset
`define TAOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("taoc check failed");

// next-cycle implication, off while in reset
`define TAOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("taoc check failed");

// what must hold in the cycle after a reset cycle
`define TAOC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("taoc reset check failed");

`endif

/* hdl/taoc_pkg.sv */
// shared types and constants of the tinted alpha-over compositor
// no dependencies
package taoc_pkg;

  localparam int COLOR_W     = 8;
  localparam int TINT_W      = 32;
  localparam int QUOT_W      = 8;
  localparam int DEN_W       = 16;
  localparam int DIV_W       = DEN_W + 1;
  localparam int NUM_W       = 26;
  localparam int PROD_W      = 2 * COLOR_W;
  localparam int TERM_W      = 3 * COLOR_W;
  localparam int LANES       = 4;
  localparam int COLOR_LANES = 3;

  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;
  localparam int LANE_ALPHA = 3;

  localparam logic [COLOR_W-1:0] COLOR_MAX    = 8'hFF;
  // alpha = floor((D + 127) / 255), the divide by 255 done as y + (y >> 8) + 1, >> 8
  localparam logic [DEN_W:0]     ALPHA_HALF   = 17'd127;
  localparam logic [DEN_W:0]     DIV255_ROUND = 17'd1;

  localparam int unsigned DIV_BITS_DEFAULT = 2;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [TINT_W-1:0]  tint_t;

  typedef struct packed {
    color_t src_red;
    color_t src_green;
    color_t src_blue;
    color_t src_alpha;
    color_t dst_red;
    color_t dst_green;
    color_t dst_blue;
    color_t dst_alpha;
  } pixel_in_t;

  typedef struct packed {
    color_t out_red;
    color_t out_green;
    color_t out_blue;
    color_t out_alpha;
    logic   was_blended;
  } pixel_out_t;

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    color_t alpha;
  } rgba_t;

  // what travels down the divider stages
  typedef struct packed {
    logic [COLOR_LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QUOT_W-1:0]      quot;
    logic [DIV_W-1:0]                  den2;
    rgba_t                             dst;
    logic                              blended;
  } div_carry_t;

endpackage

/* hdl/taoc_stream_if.sv */
// valid/ready channel used for pixels and the tint register
// payload type set per instance
interface taoc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/taoc_front.sv */
// front end: tint and coverage products, numerator and denominator, divider setup
// depends on taoc_pkg
module taoc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  taoc_pkg::tint_t        tint,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  taoc_pkg::pixel_in_t    in_pix,
  output logic                   out_valid,
  input  logic                   out_ready,
  output taoc_pkg::div_carry_t   out_carry
);
  import taoc_pkg::*;

  logic                                   tint_zero;
  logic [COLOR_LANES-1:0][COLOR_W-1:0]    tint_rgb;
  logic [COLOR_LANES-1:0][COLOR_W-1:0]    src_rgb;
  logic [COLOR_LANES-1:0][COLOR_W-1:0]    dst_rgb;

  // stage 1
  logic                                   v1;
  logic [COLOR_LANES-1:0][PROD_W-1:0]     src_tinted;
  logic [COLOR_LANES-1:0][PROD_W-1:0]     dst_cov;
  color_t                                 sa1;
  color_t                                 isa1;
  rgba_t                                  dst1;
  logic                                   bl1;

  // stage 2
  logic                                   v2;
  logic [COLOR_LANES-1:0][TERM_W-1:0]     n_src;
  logic [COLOR_LANES-1:0][TERM_W-1:0]     n_dst;
  logic [DEN_W-1:0]                       den;
  rgba_t                                  dst2;
  logic                                   bl2;

  // stage 3
  logic                                   v3;
  div_carry_t                             c3;
  div_carry_t                             c3_next;

  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;
  assign out_carry = c3;

  always_comb begin
    tint_zero = (tint == '0);
    src_rgb[LANE_RED]   = in_pix.src_red;
    src_rgb[LANE_GREEN] = in_pix.src_green;
    src_rgb[LANE_BLUE]  = in_pix.src_blue;
    dst_rgb[LANE_RED]   = in_pix.dst_red;
    dst_rgb[LANE_GREEN] = in_pix.dst_green;
    dst_rgb[LANE_BLUE]  = in_pix.dst_blue;
    // red sits in the highest of the three low bytes
    for (int c = 0; c < COLOR_LANES; c++) begin
      tint_rgb[c] = tint_zero ? COLOR_MAX : tint[(COLOR_LANES-1-c)*COLOR_W +: COLOR_W];
    end
  end

  always_comb begin
    logic [TERM_W:0]  sum;
    logic [DEN_W:0]   a_round;
    logic [DEN_W:0]   a_sum;
    c3_next = '0;
    for (int c = 0; c < COLOR_LANES; c++) begin
      sum = {1'b0, n_src[c]} + {1'b0, n_dst[c]};
      // 2N + D, divided later by 2D
      c3_next.rem[c] = NUM_W'({sum, 1'b0}) + NUM_W'(den);
    end
    // alpha is round(D / 255) straight from the denominator, no divider lane
    a_round = {1'b0, den} + ALPHA_HALF;
    a_sum   = a_round + (a_round >> COLOR_W) + DIV255_ROUND;
    c3_next.quot[LANE_ALPHA] = a_sum[COLOR_W +: COLOR_W];
    c3_next.den2    = {den, 1'b0};
    c3_next.dst     = dst2;
    c3_next.blended = bl2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int c = 0; c < COLOR_LANES; c++) begin
        src_tinted[c] <= PROD_W'(src_rgb[c]) * PROD_W'(tint_rgb[c]);
        dst_cov[c]    <= PROD_W'(dst_rgb[c]) * PROD_W'(in_pix.dst_alpha);
      end
      sa1  <= in_pix.src_alpha;
      isa1 <= COLOR_MAX - in_pix.src_alpha;
      dst1 <= '{in_pix.dst_red, in_pix.dst_green, in_pix.dst_blue, in_pix.dst_alpha};
      bl1  <= (in_pix.src_alpha != '0);
    end
    if (rdy2 && v1) begin
      for (int c = 0; c < COLOR_LANES; c++) begin
        n_src[c] <= TERM_W'(src_tinted[c]) * TERM_W'(sa1);
        n_dst[c] <= TERM_W'(dst_cov[c]) * TERM_W'(isa1);
      end
      den  <= DEN_W'(sa1) * DEN_W'(COLOR_MAX) + DEN_W'(dst1.alpha) * DEN_W'(isa1);
      dst2 <= dst1;
      bl2  <= bl1;
    end
    if (rdy3 && v2) begin
      c3 <= c3_next;
    end
  end

endmodule

/* hdl/taoc_div_stage.sv */
// one stage of the restoring divider, BITS quotient bits per stage on the three color lanes
// depends on taoc_pkg
module taoc_div_stage #(
  parameter int unsigned BITS    = taoc_pkg::DIV_BITS_DEFAULT,
  parameter int unsigned TOP_BIT = taoc_pkg::QUOT_W - 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  taoc_pkg::div_carry_t  in_carry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output taoc_pkg::div_carry_t  out_carry
);
  import taoc_pkg::*;

  logic       vld;
  div_carry_t carry;
  div_carry_t carry_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_carry = carry;

  always_comb begin
    logic [NUM_W-1:0] shifted;
    carry_next = in_carry;
    for (int j = 0; j < int'(BITS); j++) begin
      shifted = NUM_W'(in_carry.den2) << (TOP_BIT - j);
      for (int l = 0; l < COLOR_LANES; l++) begin
        if (carry_next.rem[l] >= shifted) begin
          carry_next.rem[l] = carry_next.rem[l] - shifted;
          carry_next.quot[l][TOP_BIT - j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      carry <= carry_next;
    end
  end

endmodule

/* hdl/tinted_alpha_over_compositor.sv */
// channel   dir  payload       beat when
// pix_in    in   pixel_in_t    valid & ready
// pix_out   out  pixel_out_t   valid & ready
// cfg       in   32-bit tint   valid & ready (ready always high)
//
// one pixel per clock unless the output stalls; each pixel passes through the
// three front stages and then the pipelined restoring divider
// reset (rst, synchronous) empties every stage and clears the tint to untinted
// a stalled output holds its beat; empty stages still fill while it waits
// depends on taoc_pkg, taoc_stream_if, taoc_front, taoc_div_stage
module tinted_alpha_over_compositor #(
  parameter int unsigned DIV_BITS = taoc_pkg::DIV_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  taoc_stream_if.sink   pix_in,
  taoc_stream_if.source pix_out,
  taoc_stream_if.sink   cfg
);
  import taoc_pkg::*;

  localparam int DIV_STAGES = QUOT_W / int'(DIV_BITS);

  tint_t                 tint;
  logic [DIV_STAGES:0]   vld;
  logic [DIV_STAGES:0]   rdy;
  div_carry_t            carry [DIV_STAGES+1];
  div_carry_t            last;
  pixel_out_t            result;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint <= '0;
    end else if (cfg.valid) begin
      tint <= TINT_W'(cfg.payload);
    end
  end

  taoc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tint      (tint),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .in_pix    (pix_in.payload),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_carry (carry[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    taoc_div_stage #(
      .BITS    (DIV_BITS),
      .TOP_BIT (QUOT_W - 1 - k * int'(DIV_BITS))
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_carry  (carry[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_carry (carry[k+1])
    );
  end

  assign rdy[DIV_STAGES] = pix_out.ready;
  assign last            = carry[DIV_STAGES];

  // transparent texel passes the destination through
  always_comb begin
    if (last.blended) begin
      result.out_red   = last.quot[LANE_RED];
      result.out_green = last.quot[LANE_GREEN];
      result.out_blue  = last.quot[LANE_BLUE];
      result.out_alpha = last.quot[LANE_ALPHA];
    end else begin
      result.out_red   = last.dst.red;
      result.out_green = last.dst.green;
      result.out_blue  = last.dst.blue;
      result.out_alpha = last.dst.alpha;
    end
    result.was_blended = last.blended;
  end

  assign pix_out.valid   = vld[DIV_STAGES];
  assign pix_out.payload = result;

endmodule

/* hdl/taoc_checker.sv */
// port-level checks for the tinted alpha-over compositor, bound to the top level
// depends on taoc_pkg and tinted_alpha_over_compositor_assert.svh
`include "tinted_alpha_over_compositor_assert.svh"

module taoc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input taoc_pkg::pixel_out_t out_payload
);

  // pipeline is empty right after reset
  `TAOC_ASSERT_RST(a_empty_after_reset, !out_valid)

  // a stalled result stays put
  `TAOC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // input only backs up when every stage is full and the output is stalled
  `TAOC_ASSERT_IMP(a_backpressure_source, !in_ready, out_valid && !out_ready)

  // a blended pixel always has some coverage
  `TAOC_ASSERT_IMP(a_blend_alpha, out_valid && out_payload.was_blended,
                   out_payload.out_alpha != '0)

  // nothing comes out of an idle block unasked in the cycle after reset
  `TAOC_ASSERT_IMP(a_no_ghost, $past(rst) && !in_valid, !out_valid)

endmodule

bind tinted_alpha_over_compositor taoc_checker u_taoc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_payload (pix_out.payload)
);

/* bench/testbench.sv */
// self-checking bench for tinted_alpha_over_compositor: directed and random pixels
// under several tint settings, checked beat by beat against an in-bench blend model
// depends on taoc_pkg, taoc_stream_if and the compositor rtl
`timescale 1ns / 100ps

module testbench;
  import taoc_pkg::*;

  class composite_checker;
    tint_t      tint;
    pixel_out_t expected_pixels[$];
    int         errors;
    int         checked;
    int         pixels;
    int         transparent;

    function new();
      tint = '0;
      errors = 0;
      checked = 0;
      pixels = 0;
      transparent = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_tint(tint_t v);
      tint = v;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // round-half-up of num/den, clamped to a byte
    function color_t mix_channel(int unsigned s, int unsigned t, int unsigned d,
                                 int unsigned sa, int unsigned da, int unsigned den);
      int unsigned num;
      int unsigned q;
      num = s * t * sa + d * da * (255 - sa);
      q = (2 * num + den) / (2 * den);
      return (q > 255) ? COLOR_MAX : color_t'(q);
    endfunction

    function pixel_out_t blend_pixel(pixel_in_t p);
      pixel_out_t  r;
      int unsigned sa, da, den, a;
      int unsigned tr, tg, tb;
      sa = p.src_alpha;
      da = p.dst_alpha;
      if (sa == 0) begin
        r.out_red     = p.dst_red;
        r.out_green   = p.dst_green;
        r.out_blue    = p.dst_blue;
        r.out_alpha   = p.dst_alpha;
        r.was_blended = 1'b0;
        return r;
      end
      // a zero register means plain white, any other value uses its rgb bytes
      if (tint == '0) begin
        tr = 255;
        tg = 255;
        tb = 255;
      end else begin
        tr = tint[23:16];
        tg = tint[15:8];
        tb = tint[7:0];
      end
      den = 255 * sa + da * (255 - sa);
      a = (2 * den + 255) / 510;
      r.out_red     = mix_channel(p.src_red, tr, p.dst_red, sa, da, den);
      r.out_green   = mix_channel(p.src_green, tg, p.dst_green, sa, da, den);
      r.out_blue    = mix_channel(p.src_blue, tb, p.dst_blue, sa, da, den);
      r.out_alpha   = (a > 255) ? COLOR_MAX : color_t'(a);
      r.was_blended = 1'b1;
      return r;
    endfunction

    function void note_input(pixel_in_t p);
      expected_pixels.insert(expected_pixels.size(), blend_pixel(p));
      pixels++;
      if (p.src_alpha == '0) transparent++;
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        report("result beat with no pixel pending");
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.out_red !== want.out_red)
        report($sformatf("red got %0d want %0d", got.out_red, want.out_red));
      if (got.out_green !== want.out_green)
        report($sformatf("green got %0d want %0d", got.out_green, want.out_green));
      if (got.out_blue !== want.out_blue)
        report($sformatf("blue got %0d want %0d", got.out_blue, want.out_blue));
      if (got.out_alpha !== want.out_alpha)
        report($sformatf("alpha got %0d want %0d", got.out_alpha, want.out_alpha));
      if (got.was_blended !== want.was_blended)
        report($sformatf("was_blended got %0b want %0b", got.was_blended,
                         want.was_blended));
    endfunction

    function void flush_check();
      while (expected_pixels.size() != 0) begin
        void'(expected_pixels.pop_front());
        report("expected pixel never came out");
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;

  taoc_stream_if #(.payload_t(pixel_in_t))  pix_in ();
  taoc_stream_if #(.payload_t(pixel_out_t)) pix_out ();
  taoc_stream_if #(.payload_t(tint_t))      cfg_ch ();

  composite_checker sb;

  tinted_alpha_over_compositor u_top (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("run timed out with %0d pixels pending", sb.pending());
    $display("Some tests failed");
    $finish;
  end

  // output back-pressure
  initial begin
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pix_out.ready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) sb.check_result(pix_out.payload);
  end

  // valid stays high from one beat into the next unless a gap is taken
  task automatic send_pixel(input pixel_in_t p);
    while (!no_idle && $urandom_range(99) < 27) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid   <= 1'b1;
    pix_in.payload <= p;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    sb.note_input(p);
  endtask

  task automatic settle();
    pix_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_tint(input tint_t v);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_tint(v);
  endtask

  initial begin
    pixel_in_t directed[14];
    tint_t     tint_plan[9];
    pixel_in_t p;
    int        pick;

    sb = new();
    no_idle        <= 1'b0;
    rst            <= 1'b1;
    pix_in.valid   <= 1'b0;
    pix_in.payload <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;

    // bytes: src r g b a, dst r g b a
    directed[0]  = 64'h00_00_00_00_00_00_00_00;
    directed[1]  = 64'hFF_FF_FF_FF_FF_FF_FF_FF;
    directed[2]  = 64'hFF_FF_FF_FF_00_00_00_00;
    directed[3]  = 64'h00_00_00_FF_FF_FF_FF_FF;
    directed[4]  = 64'hFF_80_01_01_00_00_00_00;
    directed[5]  = 64'hFF_80_01_01_10_20_30_FF;
    directed[6]  = 64'h01_7F_FE_FE_FE_7F_01_FF;
    directed[7]  = 64'hC8_64_32_80_32_64_C8_80;
    // transparent texels pass the destination through
    directed[8]  = 64'hFF_FF_FF_00_0C_22_38_4E;
    directed[9]  = 64'h00_00_00_00_FF_FF_FF_FF;
    directed[10] = 64'h12_34_56_FF_AB_CD_EF_00;
    directed[11] = 64'hC8_C8_C8_80_FF_00_FF_00;
    directed[12] = 64'hAA_55_AA_55_55_AA_55_AA;
    directed[13] = 64'h55_AA_55_AA_AA_55_AA_55;

    tint_plan[0] = 32'hFF00_0000;  // nonzero register but black rgb
    tint_plan[1] = 32'hFFFF_FFFF;
    tint_plan[2] = 32'h00FF_FFFF;
    tint_plan[3] = 32'h0000_0001;
    tint_plan[4] = $urandom();
    tint_plan[5] = $urandom();
    tint_plan[6] = 32'h0000_0000;
    tint_plan[7] = $urandom();
    tint_plan[8] = 32'h00FF_00FF;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset tint is untinted white
    for (int i = 0; i < 14; i++) send_pixel(directed[i]);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      write_tint(tint_plan[ph]);
      no_idle <= (ph == 3);
      for (int n = 0; n < 105; n++) begin
        p = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 15)      p.src_alpha = 8'd0;
        else if (pick < 30) p.src_alpha = 8'hFF;
        else if (pick < 38) p.src_alpha = 8'd1;
        pick = $urandom_range(99);
        if (pick < 15)      p.dst_alpha = 8'd0;
        else if (pick < 25) p.dst_alpha = 8'hFF;
        send_pixel(p);
      end
      settle();
    end

    no_idle <= 1'b0;
    repeat (20) @(posedge clk);
    sb.flush_check();
    $display("blended %0d pixels (%0d with transparent source) under 10 tint settings",
             sb.pixels, sb.transparent);
    $display("%0d result beats compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/taoc_pkg.sv
hdl/taoc_stream_if.sv
hdl/taoc_front.sv
hdl/taoc_div_stage.sv
hdl/tinted_alpha_over_compositor.sv
hdl/taoc_checker.sv
bench/testbench.sv
